### hdl/rc4_pkg.sv
`default_nettype none

package rc4_pkg;

   localparam int BYTE_W         = 8;
   localparam int PERM_DEPTH     = 256;
   localparam int PERM_AW        = 8;
   localparam int KEY_DEPTH_DFLT = 256;

   typedef logic [BYTE_W-1:0]  byte_type;
   typedef logic [PERM_AW-1:0] perm_addr_type;

   // request kinds
   localparam logic REQ_KEY  = 1'b0;
   localparam logic REQ_DATA = 1'b1;

   // response status codes
   localparam logic STATUS_OK        = 1'b0;
   localparam logic STATUS_NOT_KEYED = 1'b1;

endpackage

`default_nettype wire

### hdl/rc4_stream_cipher.sv
// RC4 stream cipher.
// Requests arrive on req_* (valid/stall). req_type selects a key byte or a data byte.
// Key bytes are written to the key store, one per cycle while req_stall is low. The key
// byte with req_last set starts the key schedule: it fills the permutation with the
// identity, then 256 rounds that swap S[n] and S[j]. req_stall stays high while it runs.
// Key bytes past KEY_DEPTH are dropped, and the key length is capped at KEY_DEPTH.
// Each data byte gives one response on rsp_* : the byte XOR the next keystream byte.
// A data byte steps through ST_GEN_J, ST_GEN_SWAP and ST_GEN_OUT. Its read, add, swap and
// keystream lookup run one after the other through the single permutation memory, which
// has one read port and one write port. req_stall stays high until its response is loaded.
// Data that arrives before any key has been scheduled, or while a new key is loading,
// gives status 1 and out_byte 0. That response is loaded from the ST_NK_OUT step.
// A stalled response stays in the output register. The next request is still taken.
// Its result waits in its last step until the output register is free.
// Reset is synchronous. It clears the control state and the keyed flag.
// It does not clear the permutation or the key memories.
`default_nettype none

module rc4_stream_cipher
   import rc4_pkg::*;
#(
   parameter int KEY_DEPTH = KEY_DEPTH_DFLT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_type,
   input  wire byte_type    req_data_byte,
   input  wire logic        req_last,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output byte_type         rsp_out_byte,
   output logic             rsp_status,
   output logic             rsp_last_out
);

   localparam int KEY_AW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
   localparam int CNT_W  = $clog2(KEY_DEPTH + 1);
   localparam logic [CNT_W-1:0] KEY_DEPTH_CNT = CNT_W'(KEY_DEPTH);
   localparam perm_addr_type LAST_ROUND = PERM_AW'(PERM_DEPTH - 1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_SCH_RD,
      ST_SCH_J,
      ST_SCH_WN,
      ST_SCH_WJ,
      ST_GEN_J,
      ST_GEN_SWAP,
      ST_GEN_OUT,
      ST_NK_OUT
   } state_type;

   state_type           state_ff, state_in;
   perm_addr_type       i_ff, i_in;
   perm_addr_type       j_ff, j_in;
   perm_addr_type       n_ff, n_in;
   logic [KEY_AW-1:0]   kidx_ff, kidx_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    len_ff, len_in;
   logic                keyed_ff, keyed_in;
   byte_type            si_ff, si_in;
   byte_type            sj_ff, sj_in;
   perm_addr_type       t_ff, t_in;
   byte_type            byte_ff, byte_in;
   logic                last_ff, last_in;
   logic                rsp_valid_ff, rsp_valid_in;
   byte_type            rsp_byte_ff, rsp_byte_in;
   logic                rsp_status_ff, rsp_status_in;
   logic                rsp_last_ff, rsp_last_in;

   byte_type            perm_mem [PERM_DEPTH];
   byte_type            key_mem [KEY_DEPTH];
   byte_type            perm_rd_ff;
   byte_type            key_rd_ff;
   logic                perm_we;
   perm_addr_type       perm_waddr;
   byte_type            perm_wdata;
   perm_addr_type       perm_raddr;
   logic                key_we;

   perm_addr_type       sch_j;
   perm_addr_type       gen_j;
   perm_addr_type       gen_t;
   byte_type            keystream;
   logic                out_free;

   assign req_stall    = (state_ff != ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_last_out = rsp_last_ff;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign sch_j    = j_ff + perm_rd_ff + key_rd_ff;
   assign gen_j    = j_ff + perm_rd_ff;
   assign gen_t    = si_ff + perm_rd_ff;

   // forward the swap: S[i] and S[j] may be in flight when S[t] is read
   always_comb begin
      priority if (t_ff == j_ff) begin
         keystream = si_ff;
      end else if (t_ff == i_ff) begin
         keystream = sj_ff;
      end else begin
         keystream = perm_rd_ff;
      end
   end

   always_comb begin
      state_in      = state_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      n_in          = n_ff;
      kidx_in       = kidx_ff;
      count_in      = count_ff;
      len_in        = len_ff;
      keyed_in      = keyed_ff;
      si_in         = si_ff;
      sj_in         = sj_ff;
      t_in          = t_ff;
      byte_in       = byte_ff;
      last_in       = last_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_byte_in   = rsp_byte_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      perm_we       = 1'b0;
      perm_waddr    = n_ff;
      perm_wdata    = n_ff;
      perm_raddr    = i_ff + 8'd1;
      key_we        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               byte_in = req_data_byte;
               last_in = req_last;
               if (req_type == REQ_KEY) begin
                  keyed_in = 1'b0;
                  if (count_ff < KEY_DEPTH_CNT) begin
                     key_we   = 1'b1;
                     count_in = count_ff + 1'b1;
                  end
                  if (req_last) begin
                     len_in   = count_in;
                     count_in = '0;
                     i_in     = '0;
                     j_in     = '0;
                     n_in     = '0;
                     kidx_in  = '0;
                     state_in = ST_INIT;
                  end
               end else if (keyed_ff) begin
                  // read of S[i+1] is already issued
                  i_in     = i_ff + 8'd1;
                  state_in = ST_GEN_J;
               end else begin
                  state_in = ST_NK_OUT;
               end
            end
         end
         ST_INIT: begin
            perm_we = 1'b1;
            n_in    = n_ff + 8'd1;
            if (n_ff == LAST_ROUND) begin
               state_in = ST_SCH_RD;
            end
         end
         ST_SCH_RD: begin
            perm_raddr = n_ff;
            state_in   = ST_SCH_J;
         end
         ST_SCH_J: begin
            perm_raddr = sch_j;
            j_in       = sch_j;
            si_in      = perm_rd_ff;
            state_in   = ST_SCH_WN;
         end
         ST_SCH_WN: begin
            perm_we    = 1'b1;
            perm_waddr = n_ff;
            perm_wdata = perm_rd_ff;
            state_in   = ST_SCH_WJ;
         end
         ST_SCH_WJ: begin
            perm_we    = 1'b1;
            perm_waddr = j_ff;
            perm_wdata = si_ff;
            n_in       = n_ff + 8'd1;
            if (CNT_W'(kidx_ff) + 1'b1 == len_ff) begin
               kidx_in = '0;
            end else begin
               kidx_in = kidx_ff + 1'b1;
            end
            if (n_ff == LAST_ROUND) begin
               j_in     = '0;
               keyed_in = 1'b1;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_SCH_RD;
            end
         end
         ST_GEN_J: begin
            perm_raddr = gen_j;
            j_in       = gen_j;
            si_in      = perm_rd_ff;
            state_in   = ST_GEN_SWAP;
         end
         ST_GEN_SWAP: begin
            perm_we    = 1'b1;
            perm_waddr = i_ff;
            perm_wdata = perm_rd_ff;
            perm_raddr = gen_t;
            sj_in      = perm_rd_ff;
            t_in       = gen_t;
            state_in   = ST_GEN_OUT;
         end
         ST_GEN_OUT: begin
            // keep reading S[t] while held: the forwarding still gives the same byte
            perm_we    = 1'b1;
            perm_waddr = j_ff;
            perm_wdata = si_ff;
            perm_raddr = t_ff;
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_byte_in   = byte_ff ^ keystream;
               rsp_status_in = STATUS_OK;
               rsp_last_in   = last_ff;
               state_in      = ST_IDLE;
            end
         end
         ST_NK_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_byte_in   = '0;
               rsp_status_in = STATUS_NOT_KEYED;
               rsp_last_in   = last_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         i_ff         <= '0;
         j_ff         <= '0;
         n_ff         <= '0;
         kidx_ff      <= '0;
         count_ff     <= '0;
         len_ff       <= '0;
         keyed_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         n_ff         <= n_in;
         kidx_ff      <= kidx_in;
         count_ff     <= count_in;
         len_ff       <= len_in;
         keyed_ff     <= keyed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      si_ff         <= si_in;
      sj_ff         <= sj_in;
      t_ff          <= t_in;
      byte_ff       <= byte_in;
      last_ff       <= last_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (perm_we) begin
         perm_mem[perm_waddr] <= perm_wdata;
      end
      perm_rd_ff <= perm_mem[perm_raddr];
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[count_ff[KEY_AW-1:0]] <= req_data_byte;
      end
      key_rd_ff <= key_mem[kidx_ff];
   end

   a_nk_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == STATUS_NOT_KEYED) |-> (rsp_byte_ff == '0))
      else $error("not-keyed response carries a nonzero byte");

   a_sched_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCH_WJ && n_ff == LAST_ROUND)
         |=> (keyed_ff && i_ff == '0 && j_ff == '0 && state_ff == ST_IDLE))
      else $error("key schedule did not leave the generator keyed and cleared");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_GEN_OUT || state_ff == ST_NK_OUT))
      else $error("response loaded outside a result step");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= KEY_DEPTH_CNT)
      else $error("key count past key store depth");

   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCH_RD) |-> (len_ff != '0 && len_ff <= KEY_DEPTH_CNT))
      else $error("key schedule running with a bad key length");

endmodule

`default_nettype wire
